### rtl/core/rmeu_pkg.sv
// shared types and constants of the register machine execute unit
package rmeu_pkg;

  // default configuration
  localparam int RegCountDef     = 8;
  localparam int ProgramDepthDef = 1024;
  localparam int DataWidthDef    = 32;

  // entries between front and back
  localparam int QueueDepth = 2;

  // instruction mode codes as they arrive
  typedef enum logic [4:0] {
    MODE_LOAD  = 5'd0,
    MODE_MOV   = 5'd1,
    MODE_ADD   = 5'd2,
    MODE_SUB   = 5'd3,
    MODE_MUL   = 5'd4,
    MODE_DIV   = 5'd5,
    MODE_CMP   = 5'd6,
    MODE_JMP   = 5'd7,
    MODE_JE    = 5'd8,
    MODE_JNE   = 5'd9,
    MODE_JLT   = 5'd10,
    MODE_JGT   = 5'd11,
    MODE_JLE   = 5'd12,
    MODE_JGE   = 5'd13,
    MODE_PRINT = 5'd14,
    MODE_HALT  = 5'd15,
    MODE_NOP   = 5'd16
  } mode_e;

  // decoded operation class
  typedef enum logic [4:0] {
    OP_LOAD,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CMP,
    OP_JMP,
    OP_JE,
    OP_JNE,
    OP_JLT,
    OP_JGT,
    OP_JLE,
    OP_JGE,
    OP_PRINT,
    OP_HALT,
    OP_NOP
  } op_e;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_DIV_ZERO = 2'd1,
    FAULT_DIV_OVF  = 2'd2
  } fault_e;

  // input item
  typedef struct packed {
    logic [4:0]         mode;
    logic [2:0]         dst_reg;
    logic [2:0]         src_reg;
    logic               use_immediate;
    logic signed [31:0] immediate;
    logic [9:0]         jump_target;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [10:0]        next_pc;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;
    fault_e             fault;
  } out_item_t;

  // classified instruction handed from front to back
  typedef struct packed {
    op_e                op;
    logic [2:0]         dst_reg;
    logic [2:0]         src_reg;
    logic               use_immediate;
    logic signed [31:0] immediate;
    logic [9:0]         jump_target;
  } dec_item_t;

endpackage

### rtl/core/rmeu_ram.sv
// generic ram, one write port, two registered read ports
module rmeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/core/rmeu_queue.sv
// short queue of classified instructions between front and back
module rmeu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rmeu_pkg::dec_item_t push_item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output rmeu_pkg::dec_item_t head_o
);

  localparam int PtrW = (rmeu_pkg::QueueDepth > 1) ? $clog2(rmeu_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(rmeu_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(rmeu_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(rmeu_pkg::QueueDepth);

  rmeu_pkg::dec_item_t ent_q [rmeu_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign do_push = push_i && (cnt_q != CntFull);
  assign do_pop  = pop_i && (cnt_q != '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= push_item_i;
    end
  end

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];

endmodule

### rtl/core/rmeu_front.sv
// front end: accepts instructions, classifies the mode and reduces register indexes
module rmeu_front #(
  parameter int REG_COUNT = rmeu_pkg::RegCountDef
) (
  input  logic                in_valid_i,
  input  rmeu_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output rmeu_pkg::dec_item_t item_o
);

  localparam logic [4:0] RegCnt = 5'(REG_COUNT);

  // index modulo register count, at most four subtractions for a 3-bit index
  function automatic logic [2:0] reduce_idx(logic [2:0] v);
    logic [4:0] t;
    t = {2'b00, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= RegCnt) begin
        t = t - RegCnt;
      end
    end
    return t[2:0];
  endfunction

  rmeu_pkg::op_e op;

  // mode classification, unknown modes behave as no-op
  always_comb begin
    case (in_item_i.mode)
      rmeu_pkg::MODE_LOAD:  op = rmeu_pkg::OP_LOAD;
      rmeu_pkg::MODE_MOV:   op = rmeu_pkg::OP_MOV;
      rmeu_pkg::MODE_ADD:   op = rmeu_pkg::OP_ADD;
      rmeu_pkg::MODE_SUB:   op = rmeu_pkg::OP_SUB;
      rmeu_pkg::MODE_MUL:   op = rmeu_pkg::OP_MUL;
      rmeu_pkg::MODE_DIV:   op = rmeu_pkg::OP_DIV;
      rmeu_pkg::MODE_CMP:   op = rmeu_pkg::OP_CMP;
      rmeu_pkg::MODE_JMP:   op = rmeu_pkg::OP_JMP;
      rmeu_pkg::MODE_JE:    op = rmeu_pkg::OP_JE;
      rmeu_pkg::MODE_JNE:   op = rmeu_pkg::OP_JNE;
      rmeu_pkg::MODE_JLT:   op = rmeu_pkg::OP_JLT;
      rmeu_pkg::MODE_JGT:   op = rmeu_pkg::OP_JGT;
      rmeu_pkg::MODE_JLE:   op = rmeu_pkg::OP_JLE;
      rmeu_pkg::MODE_JGE:   op = rmeu_pkg::OP_JGE;
      rmeu_pkg::MODE_PRINT: op = rmeu_pkg::OP_PRINT;
      rmeu_pkg::MODE_HALT:  op = rmeu_pkg::OP_HALT;
      default:              op = rmeu_pkg::OP_NOP;
    endcase
  end

  // classified item into the queue
  always_comb begin
    item_o.op            = op;
    item_o.dst_reg       = reduce_idx(in_item_i.dst_reg);
    item_o.src_reg       = reduce_idx(in_item_i.src_reg);
    item_o.use_immediate = in_item_i.use_immediate;
    item_o.immediate     = in_item_i.immediate;
    item_o.jump_target   = in_item_i.jump_target;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

### rtl/core/rmeu_muldiv.sv
// shared iterative unit: shift-add multiply and restoring signed divide
module rmeu_muldiv #(
  parameter int DATA_WIDTH = rmeu_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  is_div_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int CntW = $clog2(DATA_WIDTH + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

  logic                  busy_q;
  logic                  done_q;
  logic                  div_q;
  logic                  neg_q;
  logic [CntW-1:0]       cnt_q;
  logic [DATA_WIDTH-1:0] acc_q;   // product sum or remainder
  logic [DATA_WIDTH-1:0] opa_q;   // multiplicand or dividend/quotient
  logic [DATA_WIDTH-1:0] opb_q;   // multiplier or divisor
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_diff;

  // operand magnitudes for divide
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // one restoring divide step
  assign rem_sh   = {acc_q, opa_q[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, opb_q};

  // iteration control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      opa_q  <= '0;
      opb_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= '0;
        div_q  <= is_div_i;
        if (is_div_i) begin
          opa_q <= mag_a;
          opb_q <= mag_b;
          neg_q <= a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
        end else begin
          opa_q <= a_i;
          opb_q <= b_i;
          neg_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (div_q) begin
          if (!rem_diff[DATA_WIDTH]) begin
            acc_q <= rem_diff[DATA_WIDTH-1:0];
            opa_q <= {opa_q[DATA_WIDTH-2:0], 1'b1};
          end else begin
            acc_q <= rem_sh[DATA_WIDTH-1:0];
            opa_q <= {opa_q[DATA_WIDTH-2:0], 1'b0};
          end
        end else begin
          if (opb_q[0]) begin
            acc_q <= acc_q + opa_q;
          end
          opa_q <= {opa_q[DATA_WIDTH-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[DATA_WIDTH-1:1]};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~opa_q + 1'b1) : opa_q) : acc_q;

endmodule

### rtl/core/rmeu_back.sv
// back end: register file, program counter, run flag and execution sequencer
module rmeu_back #(
  parameter int REG_COUNT     = rmeu_pkg::RegCountDef,
  parameter int PROGRAM_DEPTH = rmeu_pkg::ProgramDepthDef,
  parameter int DATA_WIDTH    = rmeu_pkg::DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rmeu_pkg::dec_item_t  q_item_i,
  output logic                 q_pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output rmeu_pkg::out_item_t  out_item_o
);

  localparam int IdxW = $clog2(REG_COUNT);
  localparam int PcW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int NpW  = (PcW + 1 > 11) ? PcW + 1 : 11;
  localparam logic [NpW-1:0] PcMax = NpW'(PROGRAM_DEPTH);
  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_EXEC,
    ST_ITER,
    ST_WB
  } state_e;

  function automatic logic is_jump(rmeu_pkg::op_e op);
    return (op == rmeu_pkg::OP_JMP) || (op == rmeu_pkg::OP_JE) ||
           (op == rmeu_pkg::OP_JNE) || (op == rmeu_pkg::OP_JLT) ||
           (op == rmeu_pkg::OP_JGT) || (op == rmeu_pkg::OP_JLE) ||
           (op == rmeu_pkg::OP_JGE);
  endfunction

  state_e                st_q;
  rmeu_pkg::dec_item_t   item_q;
  logic [PcW-1:0]        pc_q;
  logic                  run_q;
  logic [REG_COUNT-1:0]  vld_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  out_valid_q;
  rmeu_pkg::out_item_t   out_item_q;

  logic                  out_ready;
  logic                  emit;
  logic                  fetch;
  logic [IdxW-1:0]       ra_head;
  logic [IdxW-1:0]       rb_head;
  logic [IdxW-1:0]       a_idx;
  logic [IdxW-1:0]       b_idx;
  logic [DATA_WIDTH-1:0] ram_a;
  logic [DATA_WIDTH-1:0] ram_b;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [DATA_WIDTH-1:0] rhs;
  logic [DATA_WIDTH-1:0] cmp_res;
  logic                  div_zero;
  logic                  div_ovf;
  logic                  take;
  logic [NpW-1:0]        pc_ext;
  logic [NpW-1:0]        next_raw;
  logic [NpW-1:0]        next_pc;
  logic                  we;
  logic [IdxW-1:0]       wa;
  logic [DATA_WIDTH-1:0] wd;
  logic                  md_start;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_result;
  rmeu_pkg::out_item_t   exec_res;
  rmeu_pkg::out_item_t   wb_res;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign fetch     = (st_q == ST_FETCH) && q_valid_i;
  assign q_pop_o   = fetch;

  // a result enters the output register
  assign emit = out_ready && (((st_q == ST_EXEC) && !md_start) || (st_q == ST_WB));

  // register read addresses, jumps read register zero on port b
  assign ra_head = IdxW'(q_item_i.dst_reg);
  assign rb_head = is_jump(q_item_i.op) ? '0 : IdxW'(q_item_i.src_reg);
  assign a_idx   = IdxW'(item_q.dst_reg);
  assign b_idx   = is_jump(item_q.op) ? '0 : IdxW'(item_q.src_reg);

  rmeu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REG_COUNT)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .re_i      (fetch),
    .raddr_a_i (ra_head),
    .raddr_b_i (rb_head),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // never written registers read as zero
  assign opa = vld_q[a_idx] ? ram_a : '0;
  assign opb = vld_q[b_idx] ? ram_b : '0;

  // operand selection and compare
  assign imm_ext = DATA_WIDTH'(item_q.immediate);
  assign rhs     = item_q.use_immediate ? imm_ext : opb;
  always_comb begin
    if (opa == rhs) begin
      cmp_res = '0;
    end else if ($signed(opa) < $signed(rhs)) begin
      cmp_res = '1;
    end else begin
      cmp_res = DATA_WIDTH'(1);
    end
  end

  assign div_zero = (opb == '0);
  assign div_ovf  = (opa == SignBit) && (opb == '1);

  // jump condition on register zero
  always_comb begin
    case (item_q.op)
      rmeu_pkg::OP_JMP: take = 1'b1;
      rmeu_pkg::OP_JE:  take = (opb == '0);
      rmeu_pkg::OP_JNE: take = (opb != '0);
      rmeu_pkg::OP_JLT: take = opb[DATA_WIDTH-1];
      rmeu_pkg::OP_JGT: take = !opb[DATA_WIDTH-1] && (opb != '0);
      rmeu_pkg::OP_JLE: take = opb[DATA_WIDTH-1] || (opb == '0);
      rmeu_pkg::OP_JGE: take = !opb[DATA_WIDTH-1];
      default:          take = 1'b0;
    endcase
  end

  // next program counter, saturating at program depth
  assign pc_ext   = NpW'(pc_q);
  assign next_raw = (take && (st_q == ST_EXEC)) ? NpW'(item_q.jump_target) : pc_ext + 1'b1;
  assign next_pc  = (next_raw > PcMax) ? PcMax : next_raw;

  // register file write
  always_comb begin
    we = 1'b0;
    wa = a_idx;
    wd = '0;
    if ((st_q == ST_EXEC) && run_q && out_ready) begin
      case (item_q.op)
        rmeu_pkg::OP_LOAD: begin
          we = 1'b1;
          wd = imm_ext;
        end
        rmeu_pkg::OP_MOV: begin
          we = 1'b1;
          wd = opb;
        end
        rmeu_pkg::OP_ADD: begin
          we = 1'b1;
          wd = opa + opb;
        end
        rmeu_pkg::OP_SUB: begin
          we = 1'b1;
          wd = opa - opb;
        end
        rmeu_pkg::OP_CMP: begin
          we = 1'b1;
          wa = '0;
          wd = cmp_res;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if ((st_q == ST_WB) && out_ready) begin
      we = 1'b1;
      wd = res_q;
    end
  end

  // multiply, and divide without fault, go to the iterative unit
  assign md_start = (st_q == ST_EXEC) && run_q &&
                    ((item_q.op == rmeu_pkg::OP_MUL) ||
                     ((item_q.op == rmeu_pkg::OP_DIV) && !div_zero && !div_ovf));

  rmeu_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .is_div_i (item_q.op == rmeu_pkg::OP_DIV),
    .a_i      (opa),
    .b_i      (opb),
    .done_o   (md_done),
    .result_o (md_result)
  );

  // result of a single-step instruction
  always_comb begin
    exec_res.next_pc     = run_q ? next_pc[10:0] : pc_ext[10:0];
    exec_res.print_valid = run_q && (item_q.op == rmeu_pkg::OP_PRINT);
    exec_res.print_value = exec_res.print_valid ? 32'(opa) : '0;
    exec_res.halted      = !run_q || (item_q.op == rmeu_pkg::OP_HALT);
    exec_res.fault       = rmeu_pkg::FAULT_NONE;
    if (run_q && (item_q.op == rmeu_pkg::OP_DIV)) begin
      if (div_zero) begin
        exec_res.fault = rmeu_pkg::FAULT_DIV_ZERO;
      end else if (div_ovf) begin
        exec_res.fault = rmeu_pkg::FAULT_DIV_OVF;
      end
    end
  end

  // result of a multiply or divide
  always_comb begin
    wb_res.next_pc     = next_pc[10:0];
    wb_res.print_valid = 1'b0;
    wb_res.print_value = '0;
    wb_res.halted      = 1'b0;
    wb_res.fault       = rmeu_pkg::FAULT_NONE;
  end

  // sequencer, architectural state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_FETCH;
      item_q      <= '0;
      pc_q        <= '0;
      run_q       <= 1'b1;
      vld_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
      case (st_q)
        ST_FETCH: begin
          if (q_valid_i) begin
            item_q <= q_item_i;
            st_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (md_start) begin
            st_q <= ST_ITER;
          end else if (out_ready) begin
            out_item_q <= exec_res;
            if (run_q) begin
              pc_q <= PcW'(next_pc);
              if (item_q.op == rmeu_pkg::OP_HALT) begin
                run_q <= 1'b0;
              end
            end
            st_q <= ST_FETCH;
          end
        end
        ST_ITER: begin
          if (md_done) begin
            res_q <= md_result;
            st_q  <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_ready) begin
            out_item_q <= wb_res;
            pc_q       <= PcW'(next_pc);
            st_q       <= ST_FETCH;
          end
        end
        default: begin
          st_q <= ST_FETCH;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/core/register_machine_execute_unit.sv
// top level of the register machine execute unit: front, queue and back
//
//   channel   valid        stall        payload
//   input     in_valid_i   in_stall_o   in_item_i  (rmeu_pkg::in_item_t)
//   result    out_valid_o  out_stall_i  out_item_o (rmeu_pkg::out_item_t)
//
// Each instruction passes through two back-end states, register read and execute.
// Multiply and divide then iterate in the shared shift-add / shift-subtract unit
// and pass a write-back step before the result is emitted.
// The front takes instructions while the two-entry queue has room, also while
// the back waits on the multiply/divide unit or on a stalled result.
// After reset the registers read as zero through per-register valid bits, with
// no clearing pass, so an instruction can be taken as soon as reset is released.
module register_machine_execute_unit #(
  parameter int REG_COUNT     = rmeu_pkg::RegCountDef,
  parameter int PROGRAM_DEPTH = rmeu_pkg::ProgramDepthDef,
  parameter int DATA_WIDTH    = rmeu_pkg::DataWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmeu_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmeu_pkg::out_item_t out_item_o
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  rmeu_pkg::dec_item_t dec_item;
  rmeu_pkg::dec_item_t head_item;

  // accept and classify
  rmeu_front #(
    .REG_COUNT (REG_COUNT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .item_o     (dec_item)
  );

  // decoupling queue
  rmeu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (dec_item),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  // execute
  rmeu_back #(
    .REG_COUNT     (REG_COUNT),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
